// ----- hw/rtl/url_percent_decoder_top_assert.svh -----
// Assertion macros for the URL percent decoder
`ifndef URL_PERCENT_DECODER_TOP_ASSERT_SVH
`define URL_PERCENT_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define UPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/upd_pkg.sv -----
package upd_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic REG_COMPAT_MODE = 1'b0;

    typedef struct packed {
        logic [7:0] in_char;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_end;
        logic       decode_error;
    } t_out_item;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } t_esc_phase;

endpackage

// ----- hw/rtl/upd_apb_regs.sv -----
module upd_apb_regs
    import upd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  o_compat_mode
);

    logic r_compat_mode;
    logic w_hit;

    assign w_hit  = (paddr[2] == REG_COMPAT_MODE);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compat_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_compat_mode <= pwdata[0];
        end
    end

    assign prdata        = w_hit ? {{(APB_DATA_W-1){1'b0}}, r_compat_mode} : '0;
    assign o_compat_mode = r_compat_mode;

endmodule

// ----- hw/rtl/upd_decode.sv -----
module upd_decode
    import upd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  t_in_item  i_item,
    input  logic      i_compat_mode,
    output t_out_item o_result
);

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h57)};
        end
        return v;
    endfunction

    t_esc_phase r_phase, n_phase, w_step_phase;
    logic [3:0] r_nibble, n_nibble, w_step_nibble;
    logic       r_failed, n_failed, w_step_failed;
    logic [4:0] w_hex;

    assign w_hex = hex_value(i_item.in_char);

    always_comb begin
        w_step_phase  = r_phase;
        w_step_nibble = r_nibble;
        w_step_failed = r_failed;
        if (!r_failed) begin
            unique case (r_phase)
                ESC_HIGH: begin
                    if (w_hex[4]) begin
                        w_step_nibble = w_hex[3:0];
                        w_step_phase  = ESC_LOW;
                    end else begin
                        w_step_failed = 1'b1;
                    end
                end
                ESC_LOW: begin
                    if (w_hex[4]) begin
                        w_step_phase = ESC_IDLE;
                    end else begin
                        w_step_failed = 1'b1;
                    end
                end
                default: begin
                    w_step_phase = (i_item.in_char == CH_PERCENT) ? ESC_HIGH : ESC_IDLE;
                end
            endcase
        end
        n_phase  = w_step_phase;
        n_nibble = w_step_nibble;
        n_failed = w_step_failed;
        if (i_item.is_last) begin
            n_phase  = ESC_IDLE;
            n_nibble = '0;
            n_failed = 1'b0;
        end
    end

    always_comb begin
        o_result            = '0;
        o_result.string_end = i_item.is_last;
        if (!r_failed) begin
            unique case (r_phase)
                ESC_HIGH: begin
                    o_result.byte_valid = 1'b0;
                end
                ESC_LOW: begin
                    if (w_hex[4]) begin
                        o_result.out_byte   = {r_nibble, w_hex[3:0]};
                        o_result.byte_valid = 1'b1;
                    end
                end
                default: begin
                    if (i_item.in_char != CH_PERCENT) begin
                        o_result.byte_valid = 1'b1;
                        o_result.out_byte   = (i_item.in_char == CH_PLUS && !i_compat_mode)
                                            ? CH_SPACE : i_item.in_char;
                    end
                end
            endcase
        end
        o_result.decode_error = i_item.is_last && (w_step_failed || w_step_phase != ESC_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ESC_IDLE;
            r_nibble <= '0;
            r_failed <= 1'b0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_nibble <= n_nibble;
            r_failed <= n_failed;
        end
    end

endmodule

// ----- hw/rtl/url_percent_decoder_top.sv -----
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_ready    i_in_item  (t_in_item)
// result    out        o_out_valid / i_out_ready  o_out_item (t_out_item)
// config    in         APB psel/penable/pready    paddr, pwdata, prdata
//
// One request per cycle unless stalled, one result per request.
// The escape state registers (phase, nibble, failed) are the only loop in the decoder.
// Synchronous active-low reset clears the stage valids, escape state and compat_mode.
// A stalled result holds in the output register; the input register keeps
// accepting until both stages are full.
module url_percent_decoder_top
    import upd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

`include "url_percent_decoder_top_assert.svh"

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item w_result;
    logic      w_out_adv;
    logic      w_move;
    logic      w_compat_mode;

    upd_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_compat_mode (w_compat_mode)
    );

    upd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_move),
        .i_item        (r_in_item),
        .i_compat_mode (w_compat_mode),
        .o_result      (w_result)
    );

    assign w_out_adv  = !r_out_valid || i_out_ready;
    assign w_move     = r_in_valid && w_out_adv;
    assign o_in_ready = !r_in_valid || w_out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
        if (w_move) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `UPD_ASSERT_NOW(a_no_byte_zero, r_out_valid && !r_out_item.byte_valid,
        r_out_item.out_byte == 8'h00, "out_byte set without byte_valid")
    `UPD_ASSERT_NOW(a_error_only_at_end, r_out_valid && !r_out_item.string_end,
        !r_out_item.decode_error, "decode_error outside string_end")
    `UPD_ASSERT_NOW(a_stall_only_when_full, !o_in_ready,
        r_in_valid && r_out_valid, "input stalled with a free stage")
    `UPD_ASSERT_NEXT(a_move_fills_output, w_move,
        r_out_valid, "advanced request lost before output")

endmodule

// ----- test/tb_url_percent_decoder_top.sv -----
module tb_url_percent_decoder_top
    import upd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [APB_ADDR_W-1:0] COMPAT_ADDR = APB_ADDR_W'(REG_COMPAT_MODE) << 2;
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR  = COMPAT_ADDR + APB_ADDR_W'(4);
    localparam int PHASE_ITEMS = 250;
    localparam int HOLD_LEN    = 60;
    localparam int IDLE_LIMIT  = 2000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    t_in_item   char_q[$];
    t_out_item  decoded_q[$];
    int         items_added = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_req = 0;
    int         hold_ack = 0;
    int         hold_left = 0;
    int         idle_cycles = 0;
    int         fail_cnt = 0;

    logic       plus_literal = 1'b0;
    t_esc_phase esc_phase = ESC_IDLE;
    logic [3:0] esc_high = '0;
    logic       str_failed = 1'b0;

    url_percent_decoder_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_out_item decode_char(t_in_item req);
        t_out_item  res;
        logic [7:0] c;
        logic [4:0] d;
        res = '0;
        c = req.in_char;
        if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41 + 8'd10);
        else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61 + 8'd10);
        else d = 5'd16;
        if (!str_failed) begin
            case (esc_phase)
                ESC_HIGH: begin
                    if (d[4]) begin
                        str_failed = 1'b1;
                    end else begin
                        esc_high = d[3:0];
                        esc_phase = ESC_LOW;
                    end
                end
                ESC_LOW: begin
                    if (d[4]) begin
                        str_failed = 1'b1;
                    end else begin
                        res.out_byte = {esc_high, d[3:0]};
                        res.byte_valid = 1'b1;
                        esc_phase = ESC_IDLE;
                    end
                end
                default: begin
                    esc_phase = ESC_IDLE;
                    if (c == CH_PERCENT) begin
                        esc_phase = ESC_HIGH;
                    end else if (c == CH_PLUS && !plus_literal) begin
                        res.out_byte = CH_SPACE;
                        res.byte_valid = 1'b1;
                    end else begin
                        res.out_byte = c;
                        res.byte_valid = 1'b1;
                    end
                end
            endcase
        end
        res.string_end = req.is_last;
        res.decode_error = req.is_last && (str_failed || esc_phase != ESC_IDLE);
        if (req.is_last) begin
            esc_phase = ESC_IDLE;
            esc_high = '0;
            str_failed = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [7:0] hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(15));
        if (v < 8'd10) return 8'h30 + v;
        return ($urandom_range(1) ? 8'h61 : 8'h41) + v - 8'd10;
    endfunction

    task automatic add_char(input logic [7:0] c, input logic last);
        t_in_item req;
        req.in_char = c;
        req.is_last = last;
        char_q.push_back(req);
        items_added++;
    endtask

    task automatic add_random_string();
        logic [7:0] s[$];
        logic [7:0] edge_chars[6];
        int n;
        int r;
        edge_chars = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 35) begin
                s.push_back(8'($urandom_range(255)));
            end else if (r < 50) begin
                s.push_back(CH_PLUS);
            end else if (r < 85) begin
                s.push_back(CH_PERCENT);
                s.push_back(hex_char());
                s.push_back(hex_char());
            end else if (r < 93) begin
                s.push_back(CH_PERCENT);
                if ($urandom_range(1)) s.push_back(hex_char());
                if ($urandom_range(1)) s.push_back(edge_chars[$urandom_range(5)]);
                else s.push_back(8'($urandom_range(255)));
            end else begin
                s.push_back($urandom_range(2) == 0 ? CH_PERCENT : 8'($urandom_range(255)));
            end
        end
        if ($urandom_range(99) < 8) begin
            s.push_back(CH_PERCENT);
            if ($urandom_range(1)) s.push_back(hex_char());
        end
        foreach (s[k]) add_char(s[k], k == s.size() - 1);
    endtask

    task automatic add_random_phase();
        int start;
        start = items_added;
        while (items_added - start < PHASE_ITEMS) add_random_string();
    endtask

    task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data,
                            output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_mode(input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b1, addr, data, rd);
        if ((addr >> 2) == APB_ADDR_W'(REG_COMPAT_MODE)) plus_literal = data[0];
        apb_xfer(1'b0, COMPAT_ADDR, '0, rd);
        if (rd[0] !== plus_literal) begin
            if (fail_cnt < 10)
                $display("compat_mode readback: expected %0b got %0b", plus_literal, rd[0]);
            fail_cnt++;
        end
    endtask

    task automatic wait_drained();
        while (char_q.size() != 0 || i_in_valid || decoded_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_item <= char_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_ack != hold_req) begin
            i_out_ready <= 1'b0;
            hold_ack <= hold_req;
            hold_left <= HOLD_LEN - 1;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) decoded_q.push_back(decode_char(i_in_item));
            if (o_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("unexpected result: byte %02h valid %0b end %0b err %0b",
                                 o_out_item.out_byte, o_out_item.byte_valid,
                                 o_out_item.string_end, o_out_item.decode_error);
                    fail_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_item.out_byte !== want.out_byte ||
                        o_out_item.byte_valid !== want.byte_valid ||
                        o_out_item.string_end !== want.string_end ||
                        o_out_item.decode_error !== want.decode_error) begin
                        if (fail_cnt < 10)
                            $display("mismatch: expected byte %02h valid %0b end %0b err %0b, %s",
                                     want.out_byte, want.byte_valid, want.string_end,
                                     want.decode_error,
                                     $sformatf("got byte %02h valid %0b end %0b err %0b",
                                               o_out_item.out_byte, o_out_item.byte_valid,
                                               o_out_item.string_end,
                                               o_out_item.decode_error));
                        fail_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        add_char(8'h00, 1'b1);
        add_char(8'hFF, 1'b0);
        add_char(8'h41, 1'b1);
        add_char(CH_PLUS, 1'b1);
        add_char(CH_PERCENT, 1'b0);
        add_char(8'h46, 1'b0);
        add_char(8'h46, 1'b0);
        add_char(CH_PERCENT, 1'b0);
        add_char(8'h30, 1'b0);
        add_char(8'h30, 1'b0);
        add_char(CH_PERCENT, 1'b0);
        add_char(8'h61, 1'b0);
        add_char(8'h39, 1'b0);
        add_char(CH_PERCENT, 1'b0);
        add_char(8'h42, 1'b0);
        add_char(8'h66, 1'b1);
        // bad high digit, then drop the rest of the string
        add_char(CH_PERCENT, 1'b0);
        add_char(8'h47, 1'b0);
        add_char(8'h78, 1'b0);
        add_char(CH_PLUS, 1'b1);
        add_char(CH_PERCENT, 1'b0);
        add_char(8'h34, 1'b0);
        add_char(8'h7A, 1'b1);
        // string ends with the escape still open
        add_char(CH_PERCENT, 1'b0);
        add_char(8'h34, 1'b1);
        add_char(CH_PERCENT, 1'b1);
        wait_drained();

        write_mode(COMPAT_ADDR, 32'hFFFF_FFFF);
        @(negedge i_clk);
        send_idle_pct = 35;
        recv_idle_pct = 47;
        add_random_phase();
        wait_drained();

        write_mode(SPARE_ADDR, 32'h0000_0000);
        write_mode(COMPAT_ADDR, 32'hFFFF_FFFE);
        @(negedge i_clk);
        send_idle_pct = 47;
        recv_idle_pct = 35;
        add_random_phase();
        wait_drained();

        write_mode(COMPAT_ADDR, 32'h0000_0001);
        @(negedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_phase();
        hold_req = hold_req + 1;
        wait_drained();

        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
